@@ rtl/ffha_pkg.sv @@
package ffha_pkg;

    localparam int HEAP_BYTES   = 32768;
    localparam int ALIGN_BYTES  = 4;
    localparam int HEADER_BYTES = 4;

    localparam int OFF_W  = $clog2(HEAP_BYTES) + 1;
    localparam int SIZE_W = OFF_W - 1;
    localparam int SLOTS  = HEAP_BYTES / 4;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int WANT_W = 17;

    localparam logic [2:0] REQ_ALLOC  = 3'd0;
    localparam logic [2:0] REQ_FREE   = 3'd1;
    localparam logic [2:0] REQ_RESIZE = 3'd2;
    localparam logic [2:0] REQ_DEFRAG = 3'd3;
    localparam logic [2:0] REQ_MON    = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;

    typedef struct packed {
        logic              used;
        logic [SIZE_W-1:0] size;
    } hdr_t;

    localparam hdr_t HDR_RESET = '{used: 1'b0, size: SIZE_W'(HEAP_BYTES - HEADER_BYTES)};

endpackage

@@ rtl/ffha_hdr_mem.sv @@
module ffha_hdr_mem
    import ffha_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SLOT_W-1:0] raddr,
    input  logic              we,
    input  logic [SLOT_W-1:0] waddr,
    input  hdr_t              wdata,
    output hdr_t              rdata
);

    hdr_t mem [SLOTS];
    hdr_t q_reg;
    logic zero_hit_reg;
    logic slot0_wr_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        q_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot0_wr_reg <= 1'b0;
            zero_hit_reg <= 1'b0;
        end
        else
        begin
            if (we && waddr == '0)
            begin
                slot0_wr_reg <= 1'b1;
            end
            zero_hit_reg <= (raddr == '0) && !slot0_wr_reg;
        end
    end

    assign rdata = zero_hit_reg ? HDR_RESET : q_reg;

endmodule

@@ rtl/first_fit_heap_allocator.sv @@
// First-fit heap allocator. One request is taken at a time; s_axis_tready is high only
// while the block is idle, and a finished result may wait in the output register while
// the next request is taken. A request walks the block chain through a header memory
// with one read port, one write port and registered read data, using a read state and
// an evaluate state per header visited. Allocate walks the chain, writes the split-off
// free header if any and then the block header, and ends in the output state; free and
// resize walk to their block the same way, and a resize that must move walks the chain
// again as allocate. A merge reads each following free block it absorbs, then writes
// the merged header. Defragment walks every block and merges each run of free blocks.
// Monitor walks every block, then divides by shift and subtract when free space remains;
// zero-size and unknown requests go straight to output. No clearing pass follows reset.
module first_fit_heap_allocator
    import ffha_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,  // size_bytes[15:0], block_offset[30:16]
    input  logic [2:0]   s_axis_tuser,  // req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,  // result_offset, block_size, free_count,
                                        // used_count, free_total, free_biggest,
                                        // used_percent, frag_percent
    output logic [1:0]   m_axis_tuser   // status
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_FRD  = 5'd1;
    localparam logic [4:0] S_FEV  = 5'd2;
    localparam logic [4:0] S_TSPL = 5'd3;
    localparam logic [4:0] S_TWR  = 5'd4;
    localparam logic [4:0] S_ARD  = 5'd5;
    localparam logic [4:0] S_AEV  = 5'd6;
    localparam logic [4:0] S_ASPL = 5'd7;
    localparam logic [4:0] S_AHDR = 5'd8;
    localparam logic [4:0] S_MRD  = 5'd9;
    localparam logic [4:0] S_MEV  = 5'd10;
    localparam logic [4:0] S_MWR  = 5'd11;
    localparam logic [4:0] S_DRD  = 5'd12;
    localparam logic [4:0] S_DEV  = 5'd13;
    localparam logic [4:0] S_NRD  = 5'd14;
    localparam logic [4:0] S_NEV  = 5'd15;
    localparam logic [4:0] S_DIV  = 5'd16;
    localparam logic [4:0] S_OUT  = 5'd17;

    localparam logic [OFF_W-1:0]  HEAP_END = OFF_W'(HEAP_BYTES);
    localparam logic [OFF_W-1:0]  HDR_OFF  = OFF_W'(HEADER_BYTES);
    localparam logic [WANT_W-1:0] HDR_W    = WANT_W'(HEADER_BYTES);

    logic [4:0]        state_reg, state_next;
    logic [2:0]        req_reg, req_next;
    logic [WANT_W-1:0] want_reg, want_next;
    logic [14:0]       doff_reg, doff_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [OFF_W-1:0]  blk_reg, blk_next;
    logic              blk_ok_reg, blk_ok_next;
    logic [SIZE_W-1:0] bsz_reg, bsz_next;
    logic [SIZE_W-1:0] hsz_reg, hsz_next;
    logic [SIZE_W-1:0] asz_reg, asz_next;
    logic [OFF_W-1:0]  mbase_reg, mbase_next;
    logic [OFF_W-1:0]  msz_reg, msz_next;
    logic [OFF_W-1:0]  mnx_reg, mnx_next;
    logic              mused_reg, mused_next;
    logic [12:0]       fcnt_reg, fcnt_next;
    logic [12:0]       ucnt_reg, ucnt_next;
    logic [15:0]       ftot_reg, ftot_next;
    logic [15:0]       fbig_reg, fbig_next;
    logic [6:0]        upct_reg, upct_next;
    logic [6:0]        fpct_reg, fpct_next;
    logic [22:0]       rem_reg, rem_next;
    logic [6:0]        quo_reg, quo_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [1:0]        status_reg, status_next;
    logic [14:0]       roff_reg, roff_next;
    logic [15:0]       rsize_reg, rsize_next;

    logic              m_valid_reg, m_valid_next;
    logic [103:0]      m_data_reg, m_data_next;
    logic [1:0]        m_user_reg, m_user_next;

    logic [SLOT_W-1:0] raddr;
    logic              we;
    logic [SLOT_W-1:0] waddr;
    hdr_t              wdata;
    hdr_t              rdata;

    logic [WANT_W-1:0] in_want;
    logic [OFF_W-1:0]  nxt;
    logic [OFF_W-1:0]  data_at;
    logic              fits;
    logic              split;
    logic [22:0]       dvs;
    logic [22:0]       prod;
    logic [6:0]        quo_new;

    ffha_hdr_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .raddr (raddr),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .rdata (rdata)
    );

    assign in_want = (WANT_W'(s_axis_tdata[15:0]) + WANT_W'(ALIGN_BYTES - 1))
                     & ~WANT_W'(ALIGN_BYTES - 1);
    assign nxt     = off_reg + HDR_OFF + OFF_W'(rdata.size);
    assign data_at = off_reg + HDR_OFF;
    assign fits    = WANT_W'(rdata.size) >= want_reg;
    assign split   = (WANT_W'(rdata.size) > want_reg)
                     && (WANT_W'(rdata.size) - want_reg > HDR_W);
    assign dvs     = 23'(ftot_reg) << cnt_reg;
    assign prod    = 23'(ftot_reg) * 23'd100;
    assign quo_new = (rem_reg >= dvs) ? (quo_reg | (7'd1 << cnt_reg)) : quo_reg;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        want_next    = want_reg;
        doff_next    = doff_reg;
        off_next     = off_reg;
        blk_next     = blk_reg;
        blk_ok_next  = blk_ok_reg;
        bsz_next     = bsz_reg;
        hsz_next     = hsz_reg;
        asz_next     = asz_reg;
        mbase_next   = mbase_reg;
        msz_next     = msz_reg;
        mnx_next     = mnx_reg;
        mused_next   = mused_reg;
        fcnt_next    = fcnt_reg;
        ucnt_next    = ucnt_reg;
        ftot_next    = ftot_reg;
        fbig_next    = fbig_reg;
        upct_next    = upct_reg;
        fpct_next    = fpct_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        status_next  = status_reg;
        roff_next    = roff_reg;
        rsize_next   = rsize_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        raddr        = off_reg[SLOT_W+1:2];
        we           = 1'b0;
        waddr        = off_reg[SLOT_W+1:2];
        wdata        = '{used: 1'b0, size: '0};

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req_next    = s_axis_tuser;
                    want_next   = in_want;
                    doff_next   = s_axis_tdata[30:16];
                    off_next    = '0;
                    blk_ok_next = 1'b0;
                    status_next = ST_OK;
                    roff_next   = '0;
                    rsize_next  = '0;
                    fcnt_next   = '0;
                    ucnt_next   = '0;
                    ftot_next   = '0;
                    fbig_next   = '0;
                    upct_next   = '0;
                    fpct_next   = '0;
                    unique case (s_axis_tuser)
                        REQ_ALLOC:
                        begin
                            if (s_axis_tdata[15:0] == '0)
                            begin
                                status_next = ST_BAD;
                                state_next  = S_OUT;
                            end
                            else
                            begin
                                state_next = S_ARD;
                            end
                        end
                        REQ_RESIZE:
                        begin
                            if (s_axis_tdata[15:0] == '0)
                            begin
                                status_next = ST_BAD;
                                state_next  = S_OUT;
                            end
                            else if (s_axis_tdata[30:16] < 15'(HEADER_BYTES))
                            begin
                                state_next = S_ARD;
                            end
                            else
                            begin
                                state_next = S_FRD;
                            end
                        end
                        REQ_FREE:
                        begin
                            if (s_axis_tdata[30:16] < 15'(HEADER_BYTES))
                            begin
                                status_next = ST_BAD;
                                state_next  = S_OUT;
                            end
                            else
                            begin
                                state_next = S_FRD;
                            end
                        end
                        REQ_DEFRAG: state_next = S_DRD;
                        REQ_MON:    state_next = S_NRD;
                        default:
                        begin
                            status_next = ST_BAD;
                            state_next  = S_OUT;
                        end
                    endcase
                end
            end

            S_FRD:
            begin
                state_next = S_FEV;
            end

            S_FEV:
            begin
                if (data_at == OFF_W'(doff_reg) && rdata.used)
                begin
                    blk_next    = off_reg;
                    blk_ok_next = 1'b1;
                    bsz_next    = rdata.size;
                    if (req_reg == REQ_FREE)
                    begin
                        mbase_next = off_reg;
                        msz_next   = OFF_W'(rdata.size);
                        mused_next = 1'b0;
                        mnx_next   = nxt;
                        state_next = S_MRD;
                    end
                    else if (fits)
                    begin
                        if (split)
                        begin
                            state_next = S_TSPL;
                        end
                        else
                        begin
                            roff_next  = data_at[14:0];
                            rsize_next = 16'(rdata.size);
                            state_next = S_OUT;
                        end
                    end
                    else
                    begin
                        off_next   = '0;
                        state_next = S_ARD;
                    end
                end
                else if (data_at >= OFF_W'(doff_reg) || nxt >= HEAP_END)
                begin
                    if (req_reg == REQ_FREE)
                    begin
                        status_next = ST_BAD;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        off_next   = '0;
                        state_next = S_ARD;
                    end
                end
                else
                begin
                    off_next   = nxt;
                    state_next = S_FRD;
                end
            end

            S_TSPL:
            begin
                we         = 1'b1;
                waddr      = 13'((blk_reg + HDR_OFF + OFF_W'(want_reg)) >> 2);
                wdata      = '{used: 1'b0,
                               size: SIZE_W'(WANT_W'(bsz_reg) - want_reg - HDR_W)};
                state_next = S_TWR;
            end

            S_TWR:
            begin
                we         = 1'b1;
                waddr      = blk_reg[SLOT_W+1:2];
                wdata      = '{used: 1'b1, size: SIZE_W'(want_reg)};
                roff_next  = 15'(blk_reg + HDR_OFF);
                rsize_next = 16'(want_reg);
                state_next = S_OUT;
            end

            S_ARD:
            begin
                state_next = S_AEV;
            end

            S_AEV:
            begin
                if (!rdata.used && fits)
                begin
                    hsz_next = rdata.size;
                    if (split)
                    begin
                        asz_next   = SIZE_W'(want_reg);
                        state_next = S_ASPL;
                    end
                    else
                    begin
                        asz_next   = rdata.size;
                        state_next = S_AHDR;
                    end
                end
                else if (nxt >= HEAP_END)
                begin
                    status_next = ST_NOSPACE;
                    state_next  = S_OUT;
                end
                else
                begin
                    off_next   = nxt;
                    state_next = S_ARD;
                end
            end

            S_ASPL:
            begin
                we         = 1'b1;
                waddr      = 13'((off_reg + HDR_OFF + OFF_W'(want_reg)) >> 2);
                wdata      = '{used: 1'b0,
                               size: SIZE_W'(WANT_W'(hsz_reg) - want_reg - HDR_W)};
                state_next = S_AHDR;
            end

            S_AHDR:
            begin
                we         = 1'b1;
                waddr      = off_reg[SLOT_W+1:2];
                wdata      = '{used: 1'b1, size: asz_reg};
                roff_next  = data_at[14:0];
                rsize_next = 16'(asz_reg);
                if (blk_ok_reg)
                begin
                    mbase_next = blk_reg;
                    msz_next   = OFF_W'(bsz_reg);
                    mused_next = 1'b0;
                    mnx_next   = blk_reg + HDR_OFF + OFF_W'(bsz_reg);
                    state_next = S_MRD;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            S_MRD:
            begin
                raddr = mnx_reg[SLOT_W+1:2];
                if (mnx_reg >= HEAP_END)
                begin
                    state_next = S_MWR;
                end
                else
                begin
                    state_next = S_MEV;
                end
            end

            S_MEV:
            begin
                if (rdata.used)
                begin
                    state_next = S_MWR;
                end
                else
                begin
                    msz_next   = msz_reg + HDR_OFF + OFF_W'(rdata.size);
                    mnx_next   = mnx_reg + HDR_OFF + OFF_W'(rdata.size);
                    state_next = S_MRD;
                end
            end

            S_MWR:
            begin
                we    = 1'b1;
                waddr = mbase_reg[SLOT_W+1:2];
                wdata = '{used: mused_reg, size: SIZE_W'(msz_reg)};
                if (req_reg == REQ_DEFRAG)
                begin
                    off_next   = mbase_reg + HDR_OFF + msz_reg;
                    state_next = S_DRD;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            S_DRD:
            begin
                if (off_reg >= HEAP_END)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_DEV;
                end
            end

            S_DEV:
            begin
                if (!rdata.used)
                begin
                    mbase_next = off_reg;
                    msz_next   = OFF_W'(rdata.size);
                    mused_next = 1'b0;
                    mnx_next   = nxt;
                    state_next = S_MRD;
                end
                else
                begin
                    off_next   = nxt;
                    state_next = S_DRD;
                end
            end

            S_NRD:
            begin
                if (off_reg >= HEAP_END)
                begin
                    upct_next = 7'd100 - 7'(prod >> $clog2(HEAP_BYTES));
                    if (ftot_reg == '0)
                    begin
                        fpct_next  = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        rem_next   = 23'(fbig_reg) * 23'd100;
                        quo_next   = '0;
                        cnt_next   = 3'd6;
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    state_next = S_NEV;
                end
            end

            S_NEV:
            begin
                if (rdata.used)
                begin
                    ucnt_next = ucnt_reg + 13'd1;
                end
                else
                begin
                    fcnt_next = fcnt_reg + 13'd1;
                    ftot_next = ftot_reg + 16'(rdata.size);
                    if (16'(rdata.size) > fbig_reg)
                    begin
                        fbig_next = 16'(rdata.size);
                    end
                end
                off_next   = nxt;
                state_next = S_NRD;
            end

            S_DIV:
            begin
                if (rem_reg >= dvs)
                begin
                    rem_next = rem_reg - dvs;
                end
                quo_next = quo_new;
                cnt_next = cnt_reg - 3'd1;
                if (cnt_reg == '0)
                begin
                    fpct_next  = 7'd100 - quo_new;
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = status_reg;
                    m_data_next  = {1'b0, fpct_reg, upct_reg, fbig_reg, ftot_reg,
                                    ucnt_reg, fcnt_reg, rsize_reg, roff_reg};
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        want_reg   <= want_next;
        doff_reg   <= doff_next;
        off_reg    <= off_next;
        blk_reg    <= blk_next;
        blk_ok_reg <= blk_ok_next;
        bsz_reg    <= bsz_next;
        hsz_reg    <= hsz_next;
        asz_reg    <= asz_next;
        mbase_reg  <= mbase_next;
        msz_reg    <= msz_next;
        mnx_reg    <= mnx_next;
        mused_reg  <= mused_next;
        fcnt_reg   <= fcnt_next;
        ucnt_reg   <= ucnt_next;
        ftot_reg   <= ftot_next;
        fbig_reg   <= fbig_next;
        upct_reg   <= upct_next;
        fpct_reg   <= fpct_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        status_reg <= status_next;
        roff_reg   <= roff_next;
        rsize_reg  <= rsize_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

endmodule
